/* src/dhlt_pkg.sv */
// Package with constants, types and helper functions for the link transform core.
package dhlt_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int LENGTH_BITS = 24;
    localparam int ROT_BITS = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int CW = 34;
    localparam int ZW = 34;

    localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
    localparam logic signed [ROT_BITS-1:0] ROT_ONE = 16'sd16384;
    localparam logic signed [ZW-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [ZW-1:0] HALF = 34'sd2147483648;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [ROT_BITS-1:0] rot_t;
    typedef logic signed [LENGTH_BITS-1:0] len_t;

    // One angle in flight through the CORDIC pipeline.
    typedef struct packed {
        cval_t x;
        cval_t y;
        logic signed [ZW-1:0] z;
        logic flip;
    } cstage_t;

    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                0: r = 34'sd536870912;
                1: r = 34'sd316933406;
                2: r = 34'sd167458907;
                3: r = 34'sd85004756;
                4: r = 34'sd42667331;
                5: r = 34'sd21354465;
                6: r = 34'sd10679838;
                7: r = 34'sd5340245;
                8: r = 34'sd2670163;
                9: r = 34'sd1335087;
                10: r = 34'sd667544;
                11: r = 34'sd333772;
                12: r = 34'sd166886;
                13: r = 34'sd83443;
                14: r = 34'sd41722;
                15: r = 34'sd20861;
                16: r = 34'sd10430;
                17: r = 34'sd5215;
                18: r = 34'sd2608;
                19: r = 34'sd1304;
                20: r = 34'sd652;
                21: r = 34'sd326;
                22: r = 34'sd163;
                23: r = 34'sd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Round a Q4.30 value to Q2.14 and clamp to plus or minus one.
    function automatic rot_t round_q14(input cval_t v);
        logic signed [CW-1:0] t;
        begin
            t = (v + 34'sd32768) >>> 16;
            if (t > 34'sd16384)
                return ROT_ONE;
            else if (t < -34'sd16384)
                return -ROT_ONE;
            else
                return t[ROT_BITS-1:0];
        end
    endfunction

    function automatic rot_t rot_round(input logic signed [32:0] p);
        logic signed [32:0] t;
        begin
            t = (p + 33'sd8192) >>> 14;
            if (t > 33'sd16384)
                return ROT_ONE;
            else if (t < -33'sd16384)
                return -ROT_ONE;
            else
                return t[ROT_BITS-1:0];
        end
    endfunction

    function automatic len_t len_round(input logic signed [39:0] p);
        logic signed [39:0] t;
        begin
            t = (p + 40'sd8192) >>> 14;
            if (t > 40'sd8388607)
                return 24'sh7fffff;
            else if (t < -40'sd8388608)
                return 24'sh800000;
            else
                return t[LENGTH_BITS-1:0];
        end
    endfunction

endpackage

/* src/dhlt_cordic.sv */
// Pipelined rotation-mode CORDIC giving sine and cosine of one binary angle.
module dhlt_cordic
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [dhlt_pkg::ANGLE_BITS-1:0] angle,
    output logic                  out_valid,
    output dhlt_pkg::rot_t        sin_val,
    output dhlt_pkg::rot_t        cos_val
);

    localparam int N = dhlt_pkg::CORDIC_STAGES;

    dhlt_pkg::cstage_t stage_reg [0:N];
    logic [N+1:0] valid_reg;
    dhlt_pkg::cstage_t first_next;
    dhlt_pkg::rot_t sin_reg, cos_reg;

    always_comb
    begin
        logic signed [dhlt_pkg::ZW-1:0] z;
        z = {{2{angle[dhlt_pkg::ANGLE_BITS-1]}}, angle, {(32-dhlt_pkg::ANGLE_BITS){1'b0}}};
        first_next.x = dhlt_pkg::GAIN_INV;
        first_next.y = '0;
        first_next.flip = 1'b0;
        if (z > dhlt_pkg::QUARTER)
        begin
            z = z - dhlt_pkg::HALF;
            first_next.flip = 1'b1;
        end
        else if (z < -dhlt_pkg::QUARTER)
        begin
            z = z + dhlt_pkg::HALF;
            first_next.flip = 1'b1;
        end
        first_next.z = z;
    end

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= first_next;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (stage_reg[i].z >= 0)
            begin
                stage_reg[i+1].x <= stage_reg[i].x - (stage_reg[i].y >>> i);
                stage_reg[i+1].y <= stage_reg[i].y + (stage_reg[i].x >>> i);
                stage_reg[i+1].z <= stage_reg[i].z - dhlt_pkg::atan_step(i);
            end
            else
            begin
                stage_reg[i+1].x <= stage_reg[i].x + (stage_reg[i].y >>> i);
                stage_reg[i+1].y <= stage_reg[i].y - (stage_reg[i].x >>> i);
                stage_reg[i+1].z <= stage_reg[i].z + dhlt_pkg::atan_step(i);
            end
            stage_reg[i+1].flip <= stage_reg[i].flip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_reg[N].flip)
        begin
            cos_reg <= -dhlt_pkg::round_q14(stage_reg[N].x);
            sin_reg <= -dhlt_pkg::round_q14(stage_reg[N].y);
        end
        else
        begin
            cos_reg <= dhlt_pkg::round_q14(stage_reg[N].x);
            sin_reg <= dhlt_pkg::round_q14(stage_reg[N].y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[N:0], in_valid};
    end

    assign out_valid = valid_reg[N+1];
    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

/* src/dh_link_transform_core.sv */
// Top level of the Denavit-Hartenberg link transform core.
// The core takes one item per clock while busy is low (busy is always low here). Each
// result passes through the sixteen CORDIC stages, their input and output registers
// and two multiply stages, and is marked by done for one cycle. The receiver cannot
// stall, so no result waits.
module dh_link_transform_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [15:0]   joint_angle,
    input  logic signed [15:0]   twist_angle,
    input  logic signed [23:0]   link_length,
    input  logic signed [23:0]   link_offset,
    output logic                 done,
    output logic signed [15:0]   rot_00,
    output logic signed [15:0]   rot_01,
    output logic signed [15:0]   rot_02,
    output logic signed [15:0]   rot_10,
    output logic signed [15:0]   rot_11,
    output logic signed [15:0]   rot_12,
    output logic signed [15:0]   rot_20,
    output logic signed [15:0]   rot_21,
    output logic signed [15:0]   rot_22,
    output logic signed [23:0]   disp_x,
    output logic signed [23:0]   disp_y,
    output logic signed [23:0]   disp_z
);

    localparam int LAT = dhlt_pkg::CORDIC_STAGES + 2;

    logic accept;
    logic t_valid, a_valid;
    dhlt_pkg::rot_t st, ct, sa, ca;
    dhlt_pkg::len_t len_reg [0:LAT-1];
    dhlt_pkg::len_t off_reg [0:LAT-1];

    logic signed [32:0] p01_reg, p02_reg, p11_reg, p12_reg;
    logic signed [39:0] px_reg, py_reg;
    dhlt_pkg::rot_t st_reg, ct_reg, sa_reg, ca_reg;
    dhlt_pkg::len_t d_reg;
    logic m_valid_reg, done_reg;
    dhlt_pkg::rot_t r00_reg, r01_reg, r02_reg, r10_reg, r11_reg, r12_reg, r21_reg, r22_reg;
    dhlt_pkg::len_t dx_reg, dy_reg, dz_reg;

    assign busy = 1'b0;
    assign accept = start && !busy;

    dhlt_cordic u_theta
    (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .angle(joint_angle),
        .out_valid(t_valid), .sin_val(st), .cos_val(ct)
    );

    dhlt_cordic u_alpha
    (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .angle(twist_angle),
        .out_valid(a_valid), .sin_val(sa), .cos_val(ca)
    );

    // Lengths travel alongside the CORDIC pipelines.
    always_ff @(posedge clk)
    begin
        len_reg[0] <= link_length;
        off_reg[0] <= link_offset;
        for (int i = 1; i < LAT; i++)
        begin
            len_reg[i] <= len_reg[i-1];
            off_reg[i] <= off_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        p01_reg <= -(33'(st) * 33'(ca));
        p02_reg <= 33'(st) * 33'(sa);
        p11_reg <= 33'(ct) * 33'(ca);
        p12_reg <= -(33'(ct) * 33'(sa));
        px_reg <= 40'(len_reg[LAT-1]) * 40'(ct);
        py_reg <= 40'(len_reg[LAT-1]) * 40'(st);
        st_reg <= st;
        ct_reg <= ct;
        sa_reg <= sa;
        ca_reg <= ca;
        d_reg <= off_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        r00_reg <= ct_reg;
        r10_reg <= st_reg;
        r21_reg <= sa_reg;
        r22_reg <= ca_reg;
        r01_reg <= dhlt_pkg::rot_round(p01_reg);
        r02_reg <= dhlt_pkg::rot_round(p02_reg);
        r11_reg <= dhlt_pkg::rot_round(p11_reg);
        r12_reg <= dhlt_pkg::rot_round(p12_reg);
        dx_reg <= dhlt_pkg::len_round(px_reg);
        dy_reg <= dhlt_pkg::len_round(py_reg);
        dz_reg <= d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= t_valid;
            done_reg <= m_valid_reg;
        end
    end

    assign done = done_reg;
    assign rot_00 = r00_reg;
    assign rot_01 = r01_reg;
    assign rot_02 = r02_reg;
    assign rot_10 = r10_reg;
    assign rot_11 = r11_reg;
    assign rot_12 = r12_reg;
    assign rot_20 = '0;
    assign rot_21 = r21_reg;
    assign rot_22 = r22_reg;
    assign disp_x = dx_reg;
    assign disp_y = dy_reg;
    assign disp_z = dz_reg;

    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n) t_valid == a_valid)
        else $error("angle pipelines out of step");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(t_valid) |-> m_valid_reg)
        else $error("multiply stage lost an item");
    a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rot_11 <= 16'sd16384 && rot_11 >= -16'sd16384))
        else $error("rotation entry out of range");

endmodule

/* test/dh_link_transform_core_tb.sv */
// Testbench for the link transform core: random and corner link parameters checked
// against an in-bench fixed-point predictor.
`timescale 1ns / 100ps

module dh_link_transform_core_tb;

    typedef struct {
        logic signed [15:0] theta;
        logic signed [15:0] alpha;
        logic signed [23:0] len_a;
        logic signed [23:0] off_d;
    } link_t;

    typedef struct {
        logic signed [15:0] r [9];
        logic signed [23:0] dx;
        logic signed [23:0] dy;
        logic signed [23:0] dz;
    } xform_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [15:0] joint_angle;
    logic signed [15:0] twist_angle;
    logic signed [23:0] link_length;
    logic signed [23:0] link_offset;
    logic done;
    logic signed [15:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
    logic signed [15:0] rot_20, rot_21, rot_22;
    logic signed [23:0] disp_x, disp_y, disp_z;

    link_t link_q [$];
    xform_t xform_q [$];
    int error_count = 0;
    bit stim_done = 0;
    int item_count = 0;

    dh_link_transform_core u_dut
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .joint_angle(joint_angle), .twist_angle(twist_angle),
        .link_length(link_length), .link_offset(link_offset),
        .done(done),
        .rot_00(rot_00), .rot_01(rot_01), .rot_02(rot_02),
        .rot_10(rot_10), .rot_11(rot_11), .rot_12(rot_12),
        .rot_20(rot_20), .rot_21(rot_21), .rot_22(rot_22),
        .disp_x(disp_x), .disp_y(disp_y), .disp_z(disp_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Sine and cosine of a binary angle in Q2.14, with the same CORDIC steps as the core.
    task automatic angle_sin_cos(input logic [15:0] ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        longint steps [16];
        begin
            steps = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861};
            z = longint'({ang, 16'h0000});
            flip = 0;
            if (z >= 64'sd2147483648)
                z -= 64'sd4294967296;
            if (z > 64'sd1073741824)
            begin
                z -= 64'sd2147483648;
                flip = 1;
            end
            else if (z < -64'sd1073741824)
            begin
                z += 64'sd2147483648;
                flip = 1;
            end
            x = 652032874;
            y = 0;
            for (int i = 0; i < 16; i++)
            begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= steps[i];
                end
                else
                begin
                    x += dx; y -= dy; z += steps[i];
                end
            end
            c = clip(floor_shift(x + 32768, 16), -16384, 16384);
            s = clip(floor_shift(y + 32768, 16), -16384, 16384);
            if (flip)
            begin
                c = -c;
                s = -s;
            end
        end
    endtask

    function automatic longint q14_product(longint p, longint q, bit neg);
        longint r;
        r = neg ? -(p * q) : p * q;
        return clip(floor_shift(r + 8192, 14), -16384, 16384);
    endfunction

    task automatic predict_transform(input link_t lk);
        longint st, ct, sa, ca, a;
        xform_t t;
        begin
            angle_sin_cos(lk.theta, st, ct);
            angle_sin_cos(lk.alpha, sa, ca);
            a = lk.len_a;
            t.r[0] = 16'(ct);
            t.r[1] = 16'(q14_product(st, ca, 1));
            t.r[2] = 16'(q14_product(st, sa, 0));
            t.r[3] = 16'(st);
            t.r[4] = 16'(q14_product(ct, ca, 0));
            t.r[5] = 16'(q14_product(ct, sa, 1));
            t.r[6] = '0;
            t.r[7] = 16'(sa);
            t.r[8] = 16'(ca);
            t.dx = 24'(clip(floor_shift(a * ct + 8192, 14), -8388608, 8388607));
            t.dy = 24'(clip(floor_shift(a * st + 8192, 14), -8388608, 8388607));
            t.dz = lk.off_d;
            xform_q.push_back(t);
        end
    endtask

    function automatic link_t make_link(int th, int al, int a, int d);
        link_t lk;
        lk.theta = 16'(th);
        lk.alpha = 16'(al);
        lk.len_a = 24'(a);
        lk.off_d = 24'(d);
        return lk;
    endfunction

    function automatic logic [15:0] rand_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
        return 16'($urandom);
    endfunction

    function automatic logic [23:0] rand_length();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
        if (sel < 4)
            return 24'($signed(16'($urandom)));
        return 24'($urandom);
    endfunction

    initial
    begin
        int corners [6];
        corners = '{-32768, 32767, 0, 16384, -16384, 1};
        foreach (corners[i])
            link_q.push_back(make_link(corners[i], corners[5 - i], 8388607, -8388608));
        link_q.push_back(make_link(-32768, -32768, -8388608, 8388607));
        link_q.push_back(make_link(8192, -8192, 4096, 0));
        link_q.push_back(make_link(16383, 16385, -1, -1));
        link_q.push_back(make_link(-16385, -16383, 1, 1));
        link_q.push_back(make_link(0, 0, 0, 0));
        link_q.push_back(make_link(-1, -1, -4096, 12345));
        link_q.push_back(make_link(24576, -24576, 8388607, 8388607));
        for (int i = 0; i < 900; i++)
            link_q.push_back(make_link(int'(rand_angle()), int'(rand_angle()),
                                       int'(rand_length()), int'(rand_length())));
        stim_done = 1;
    end

    // Driver: start is held while items remain and the random gap allows it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            joint_angle <= '0;
            twist_angle <= '0;
            link_length <= '0;
            link_offset <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_transform(make_link(int'(joint_angle), int'(twist_angle),
                                            int'(link_length), int'(link_offset)));
                item_count++;
            end
            if ((start && !busy) || !start)
            begin
                // Items 300 to 499 go out back to back.
                if (link_q.size() > 0 &&
                    ((item_count >= 300 && item_count < 500) || $urandom_range(0, 99) >= 25))
                begin
                    link_t lk;
                    lk = link_q.pop_front();
                    start <= 1'b1;
                    joint_angle <= lk.theta;
                    twist_angle <= lk.alpha;
                    link_length <= lk.len_a;
                    link_offset <= lk.off_d;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, longint expv, longint act);
        if (expv != act)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, act);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (xform_q.size() == 0)
            begin
                $display("%0t: result with no item pending, actual rot_00 %0d", $time, rot_00);
                error_count++;
            end
            else
            begin
                xform_t t;
                t = xform_q.pop_front();
                check_field("rot_00", t.r[0], rot_00);
                check_field("rot_01", t.r[1], rot_01);
                check_field("rot_02", t.r[2], rot_02);
                check_field("rot_10", t.r[3], rot_10);
                check_field("rot_11", t.r[4], rot_11);
                check_field("rot_12", t.r[5], rot_12);
                check_field("rot_20", t.r[6], rot_20);
                check_field("rot_21", t.r[7], rot_21);
                check_field("rot_22", t.r[8], rot_22);
                check_field("disp_x", t.dx, disp_x);
                check_field("disp_y", t.dy, disp_y);
                check_field("disp_z", t.dz, disp_z);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        @(posedge clk);
        while (link_q.size() > 0 || start)
            @(posedge clk);
        while (xform_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("dh_link_transform_core_tb: clean");
        else
            $display("dh_link_transform_core_tb: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("dh_link_transform_core_tb: errors");
        $finish;
    end
endmodule
